@@ hdl/sfr_pkg.sv @@
// Shared types and constants of the stream find-and-replace block.
package sfr_pkg;

   localparam int unsigned LIST_BYTES  = 8;
   localparam int unsigned LIST_W      = 8 * LIST_BYTES;
   localparam int unsigned CNT_W       = 4;
   localparam int unsigned TOTAL_W     = 32;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam logic [CNT_W-1:0] MAX_REPLACE = 4'd8;

   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_BYTES      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_REPLACEMENT_BYTES  = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 8'd3;

   // At most one command per request: a list of output bytes, how many of them
   // to send, whether the text ends here, and the match count they carry.
   typedef struct packed {
      logic [LIST_W-1:0]  bytes;
      logic [CNT_W-1:0]   count;
      logic               last;
      logic [TOTAL_W-1:0] total;
   } cmd_type;

   typedef struct packed {
      logic [63:0]      pattern_bytes;
      logic [CNT_W-1:0] pattern_length;
      logic [63:0]      replacement_bytes;
      logic [CNT_W-1:0] replacement_length;
      logic             clear_fill;
   } cfg_type;

endpackage

@@ hdl/sfr_front.sv @@
// Front end: window update, pattern compare and command generation.
module sfr_front #(
   parameter int unsigned MAX_PATTERN = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  sfr_pkg::cfg_type   cfg,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tlast,
   input  logic               queue_full,
   output logic               push,
   output sfr_pkg::cmd_type   push_cmd
);

   localparam int unsigned WIN_W  = 8 * MAX_PATTERN;
   localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);

   logic [WIN_W-1:0]                window_ff, window_in;
   logic [FILL_W-1:0]               fill_ff, fill_in;
   logic [sfr_pkg::TOTAL_W-1:0]     counter_ff, counter_in;

   logic                            accept;
   logic [sfr_pkg::CNT_W-1:0]       plen, rlen, fill_eff, fill_new;
   logic [WIN_W-1:0]                win_new;
   logic                            hit;
   logic [sfr_pkg::TOTAL_W-1:0]     total_new;
   sfr_pkg::cmd_type                cmd;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      plen = (cfg.pattern_length > sfr_pkg::CNT_W'(MAX_PATTERN)) ?
             sfr_pkg::CNT_W'(MAX_PATTERN) : cfg.pattern_length;
      rlen = (cfg.replacement_length > sfr_pkg::MAX_REPLACE) ?
             sfr_pkg::MAX_REPLACE : cfg.replacement_length;
      fill_eff = (sfr_pkg::CNT_W'(fill_ff) >= plen) ? '0 : sfr_pkg::CNT_W'(fill_ff);
      fill_new = fill_eff + 4'd1;

      // Place the new byte at the current fill position.
      for (int k = 0; k < MAX_PATTERN; k++) begin
         win_new[8*k +: 8] = (sfr_pkg::CNT_W'(k) == fill_eff) ? req_tdata
                                                               : window_ff[8*k +: 8];
      end

      hit = 1'b1;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         if (sfr_pkg::CNT_W'(k) < plen &&
             win_new[8*k +: 8] != cfg.pattern_bytes[8*k +: 8]) begin
            hit = 1'b0;
         end
      end
      if (fill_new != plen) begin
         hit = 1'b0;
      end

      total_new = (hit && counter_ff != '1) ? counter_ff + 32'd1 : counter_ff;

      window_in  = window_ff;
      fill_in    = fill_ff;
      cmd.bytes  = sfr_pkg::LIST_W'(win_new);
      cmd.count  = '0;
      cmd.last   = req_tlast;
      cmd.total  = total_new;

      if (plen == '0) begin
         cmd.bytes = sfr_pkg::LIST_W'(req_tdata);
         cmd.count = 4'd1;
         fill_in   = '0;
      end else if (fill_new != plen) begin
         // Window not yet full: bytes are only sent when the text ends.
         window_in = win_new;
         fill_in   = FILL_W'(fill_new);
         cmd.count = req_tlast ? fill_new : '0;
      end else if (hit) begin
         cmd.bytes = cfg.replacement_bytes;
         cmd.count = rlen;
         fill_in   = '0;
      end else begin
         // Mismatch sends the oldest byte; at the end of text the whole window goes out.
         window_in = win_new >> 8;
         fill_in   = FILL_W'(plen - 4'd1);
         cmd.count = req_tlast ? plen : 4'd1;
      end

      if (req_tlast) begin
         fill_in = '0;
      end
      counter_in = req_tlast ? '0 : total_new;
      if (cmd.count == '0) begin
         cmd.bytes = '0;
      end
   end

   assign push     = accept && (cmd.count != '0 || req_tlast);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         counter_ff <= '0;
      end else if (cfg.clear_fill) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff    <= fill_in;
         counter_ff <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

endmodule

@@ hdl/sfr_queue.sv @@
// Short command queue between the front and back ends.
module sfr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfr_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output sfr_pkg::cmd_type head_cmd
);

   localparam int unsigned PTR_W = $clog2(sfr_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(sfr_pkg::QUEUE_DEPTH + 1);

   sfr_pkg::cmd_type  entry_ff [sfr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  used_ff, used_in;

   assign full      = (used_ff == CNT_W'(sfr_pkg::QUEUE_DEPTH));
   assign not_empty = (used_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      used_in   = used_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(sfr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(sfr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         used_in = used_ff + CNT_W'(1);
      end else if (pop && !push) begin
         used_in = used_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hdl/sfr_back.sv @@
// Back end: expands each command into result bytes, one per cycle while rsp_tready is high.
module sfr_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         queue_not_empty,
   input  sfr_pkg::cmd_type             head_cmd,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [39:0]                  rsp_tdata,
   output logic                         rsp_tuser,
   output logic                         rsp_tlast
);

   logic                          cur_valid_ff, cur_valid_in;
   logic [sfr_pkg::LIST_W-1:0]    cur_bytes_ff, cur_bytes_in;
   logic [sfr_pkg::CNT_W-1:0]     cur_left_ff, cur_left_in;
   logic                          cur_last_ff, cur_last_in;
   logic [sfr_pkg::TOTAL_W-1:0]   cur_total_ff, cur_total_in;
   logic                          sent, final_one;

   assign final_one  = (cur_left_ff <= 4'd1);
   assign sent       = cur_valid_ff && rsp_tready;
   assign pop        = queue_not_empty && (!cur_valid_ff || (sent && final_one));

   assign rsp_tvalid = cur_valid_ff;
   assign rsp_tdata  = {cur_total_ff, cur_bytes_ff[7:0]};
   assign rsp_tuser  = (cur_left_ff != '0);
   assign rsp_tlast  = cur_last_ff && final_one;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_bytes_in = cur_bytes_ff;
      cur_left_in  = cur_left_ff;
      cur_last_in  = cur_last_ff;
      cur_total_in = cur_total_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_bytes_in = head_cmd.bytes;
         cur_left_in  = head_cmd.count;
         cur_last_in  = head_cmd.last;
         cur_total_in = head_cmd.total;
      end else if (sent) begin
         if (final_one) begin
            cur_valid_in = 1'b0;
         end else begin
            cur_bytes_in = cur_bytes_ff >> 8;
            cur_left_in  = cur_left_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_bytes_ff <= cur_bytes_in;
      cur_left_ff  <= cur_left_in;
      cur_last_ff  <= cur_last_in;
      cur_total_ff <= cur_total_in;
   end

endmodule

@@ hdl/stream_find_replace.sv @@
// Top level of the streaming find-and-replace block.
//
//   Channel | Direction | Handshake             | Payload
//   req     | in        | req_tvalid/req_tready | tdata: in_byte; tlast: in_last
//   rsp     | out       | rsp_tvalid/rsp_tready | tdata: out_byte, match_total;
//           |           |                       | tuser: byte_present; tlast: out_last
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// A request is classified in the cycle it is accepted and queued as at most one command;
// the result stage sends one result per cycle while rsp_tready is high, so passing bytes
// flow at one per cycle. A match or an end of text yields up to eight results, and the
// four-entry command queue throttles requests while they drain. Reset is synchronous
// and clears all control state. Either side may stall at any time without losing a result.
module stream_find_replace #(
   parameter int unsigned MAX_PATTERN = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_byte, [39:8] match_total
   output logic        rsp_tuser,   // [0] byte_present
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic [63:0]               pattern_bytes_ff;
   logic [sfr_pkg::CNT_W-1:0] pattern_length_ff;
   logic [63:0]               replacement_bytes_ff;
   logic [sfr_pkg::CNT_W-1:0] replacement_length_ff;
   logic                      csr_write;
   sfr_pkg::cfg_type          cfg;

   logic                      push, queue_full, queue_not_empty, pop;
   sfr_pkg::cmd_type          push_cmd, head_cmd;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= '0;
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            sfr_pkg::REG_PATTERN_BYTES:      pattern_bytes_ff      <= csr_data;
            sfr_pkg::REG_PATTERN_LENGTH:     pattern_length_ff     <= csr_data[3:0];
            sfr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes_ff  <= csr_data;
            sfr_pkg::REG_REPLACEMENT_LENGTH: replacement_length_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.pattern_bytes      = pattern_bytes_ff;
      cfg.pattern_length     = pattern_length_ff;
      cfg.replacement_bytes  = replacement_bytes_ff;
      cfg.replacement_length = replacement_length_ff;
      // A new pattern length drops whatever the window holds.
      cfg.clear_fill         = csr_write && (csr_index == sfr_pkg::REG_PATTERN_LENGTH);
   end

   sfr_front #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   sfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .head_cmd  (head_cmd)
   );

   sfr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .head_cmd        (head_cmd),
      .pop             (pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast)
   );

endmodule
